>>> rtl/sba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_pkg
// Shared constants, register indexes and transfer types of the skyline
// block allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int COL_AW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COL_CW      = $clog2(MAX_COLUMNS + 1);

    localparam int HGT_W     = 9;
    localparam int TEX_W     = 13;
    localparam int POS_W     = 14;
    localparam int CHK_W     = 10;
    localparam int LOG_W     = 3;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LOG2    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLUMNS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS    = 2'd2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [TEX_W-1:0] width_texels;
        logic [TEX_W-1:0] height_texels;
    } req_t;

    typedef struct packed {
        logic             placed;
        logic [POS_W-1:0] x_texel;
        logic [POS_W-1:0] y_texel;
    } res_t;

endpackage

>>> rtl/sba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/skyline_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skyline_block_allocator
// Skyline rectangle allocator over chunk columns with a height memory.
// ----------------------------------------------------------------------------
// One request is worked at a time; s_ready is high only while the block is
// free. After reset, and for every clear request, the height memory is swept
// to zero at one column a cycle over all MAX_COLUMNS (256) columns before the
// block returns to idle or, for a clear, gives its result. An allocation runs
// a backward pass over the columns that builds per-block suffix maxima, a
// forward pass that evaluates one start column per cycle, and, when the
// rectangle is placed, a write-back of the raised columns one a cycle. Each
// pass is paced by the single read or write port of the height memory.
// Requests that are too wide, or of zero width, skip both passes and go
// straight to the check. A finished result waits in the output register
// without holding back the next request.
// ----------------------------------------------------------------------------
module skyline_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [sba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sba_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sba_pkg::req_t                 s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sba_pkg::res_t                 m_data
);

    import sba_pkg::*;

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_CLEAR = 8'b0000_0100,
        ST_BACK  = 8'b0000_1000,
        ST_FWD   = 8'b0001_0000,
        ST_CHECK = 8'b0010_0000,
        ST_WRITE = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    function automatic logic [CHK_W-1:0] to_chunks(input logic [TEX_W-1:0] t,
                                                   input logic [LOG_W-1:0] lg);
        logic [TEX_W:0] s;
        s = {1'b0, t} + ((TEX_W+1)'(1) << lg) - (TEX_W+1)'(1);
        return CHK_W'(s >> lg);
    endfunction

    function automatic logic [HGT_W-1:0] hmax(input logic [HGT_W-1:0] a,
                                              input logic [HGT_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [LOG_W-1:0]  chunk_log2_reg;
    logic [CFG_W-1:0]  block_columns_reg;
    logic [CFG_W-1:0]  block_rows_reg;

    state_t            state_reg, state_next;
    logic [COL_CW-1:0] cnt_reg, cnt_next;
    logic              iss_done_reg, iss_done_next;
    logic              dv_reg, dv_next;
    logic [COL_CW-1:0] kd_reg, kd_next;
    logic [CHK_W-1:0]  seg_reg, seg_next;
    logic [HGT_W-1:0]  suf_reg, suf_next;
    logic [HGT_W-1:0]  pre_reg, pre_next;
    logic [HGT_W-1:0]  best_reg, best_next;
    logic [COL_AW-1:0] pos_reg, pos_next;
    logic              found_reg, found_next;
    logic [CHK_W-1:0]  wc_reg, wc_next;
    logic [CHK_W-1:0]  hc_reg, hc_next;
    res_t              res_reg, res_next;
    res_t              m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;

    logic [LOG_W-1:0]  lg_eff;
    logic [COL_CW-1:0] cols_eff;
    logic [HGT_W-1:0]  rows_eff;
    logic [COL_CW-1:0] cols_m1;
    logic [COL_CW-1:0] cols_m2;
    logic [HGT_W+1:0]  top_sum;

    logic              h_we;
    logic [COL_AW-1:0] h_waddr;
    logic [HGT_W-1:0]  h_wdata;
    logic [HGT_W-1:0]  h_rdata;
    logic              s_we;
    logic              flag_wdata;
    logic              flag_rdata;
    logic [HGT_W-1:0]  suf_wdata;
    logic [HGT_W-1:0]  suf_rdata;
    logic [COL_AW-1:0] suf_raddr;

    logic              seg_zero;
    logic [HGT_W-1:0]  pre_new;
    logic [HGT_W-1:0]  win_max;

    always_comb begin
        if (chunk_log2_reg < LOG_W'(4)) begin
            lg_eff = LOG_W'(4);
        end else if (chunk_log2_reg > LOG_W'(6)) begin
            lg_eff = LOG_W'(6);
        end else begin
            lg_eff = chunk_log2_reg;
        end
        if (32'(block_columns_reg) > MAX_COLUMNS) begin
            cols_eff = COL_CW'(MAX_COLUMNS);
        end else begin
            cols_eff = COL_CW'(block_columns_reg);
        end
        if (block_rows_reg > CFG_W'(256)) begin
            rows_eff = HGT_W'(256);
        end else begin
            rows_eff = HGT_W'(block_rows_reg);
        end
    end

    assign cols_m1 = COL_CW'(32'(cols_eff) - 1);
    assign cols_m2 = COL_CW'(32'(cols_eff) - 2);
    assign top_sum = (HGT_W+2)'(best_reg) + (HGT_W+2)'(hc_reg);

    sba_ram #(.WIDTH(HGT_W), .DEPTH(MAX_COLUMNS)) u_height_ram (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (cnt_reg[COL_AW-1:0]),
        .rdata (h_rdata)
    );

    sba_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_flag_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (kd_reg[COL_AW-1:0]),
        .wdata (flag_wdata),
        .raddr (cnt_reg[COL_AW-1:0]),
        .rdata (flag_rdata)
    );

    sba_ram #(.WIDTH(HGT_W), .DEPTH(MAX_COLUMNS)) u_suffix_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (kd_reg[COL_AW-1:0]),
        .wdata (suf_wdata),
        .raddr (suf_raddr),
        .rdata (suf_rdata)
    );

    assign suf_raddr = COL_AW'(32'(cnt_reg) + 1 - 32'(wc_reg));

    // backward pass: running suffix maximum per block of wc columns
    assign seg_zero   = (seg_reg == '0);
    assign suf_wdata  = seg_zero ? h_rdata : hmax(h_rdata, suf_reg);
    assign flag_wdata = (seg_zero ? (wc_reg == CHK_W'(1)) : (seg_reg == CHK_W'(1)))
                        || (kd_reg == '0);

    // forward pass: running prefix maximum, window = suffix at start, prefix at end
    assign pre_new = flag_rdata ? h_rdata : hmax(pre_reg, h_rdata);
    assign win_max = hmax(suf_rdata, pre_new);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        iss_done_next = iss_done_reg;
        dv_next       = 1'b0;
        kd_next       = kd_reg;
        seg_next      = seg_reg;
        suf_next      = suf_reg;
        pre_next      = pre_reg;
        best_next     = best_reg;
        pos_next      = pos_reg;
        found_next    = found_reg;
        wc_next       = wc_reg;
        hc_next       = hc_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        h_we          = 1'b0;
        h_waddr       = cnt_reg[COL_AW-1:0];
        h_wdata       = '0;
        s_we          = 1'b0;

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                h_we = 1'b1;
                cnt_next = COL_CW'(32'(cnt_reg) + 1);
                if (32'(cnt_reg) == MAX_COLUMNS - 1) begin
                    if (state_reg == ST_INIT) begin
                        state_next = ST_IDLE;
                    end else begin
                        res_next   = '{placed: 1'b1, x_texel: '0, y_texel: '0};
                        state_next = ST_DONE;
                    end
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    wc_next       = to_chunks(s_data.width_texels, lg_eff);
                    hc_next       = to_chunks(s_data.height_texels, lg_eff);
                    best_next     = rows_eff;
                    found_next    = 1'b0;
                    pos_next      = '0;
                    cnt_next      = '0;
                    iss_done_next = 1'b0;
                    seg_next      = '0;
                    if (s_data.req_type == REQ_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else if (32'(wc_next) >= 32'(cols_eff)) begin
                        state_next = ST_CHECK;
                    end else if (wc_next == '0) begin
                        found_next = 1'b1;
                        pos_next   = COL_AW'(cols_m1);
                        best_next  = '0;
                        state_next = ST_CHECK;
                    end else begin
                        cnt_next   = cols_m1;
                        state_next = ST_BACK;
                    end
                end
            end
            ST_BACK: begin
                if (!iss_done_reg) begin
                    dv_next  = 1'b1;
                    kd_next  = cnt_reg;
                    cnt_next = COL_CW'(32'(cnt_reg) - 1);
                    if (cnt_reg == '0) begin
                        iss_done_next = 1'b1;
                    end
                end
                if (dv_reg) begin
                    s_we     = 1'b1;
                    suf_next = suf_wdata;
                    seg_next = seg_zero ? CHK_W'(32'(wc_reg) - 1) : CHK_W'(32'(seg_reg) - 1);
                    if (kd_reg == '0) begin
                        cnt_next      = '0;
                        iss_done_next = 1'b0;
                        state_next    = ST_FWD;
                    end
                end
            end
            ST_FWD: begin
                if (!iss_done_reg) begin
                    dv_next = 1'b1;
                    kd_next = cnt_reg;
                    if (cnt_reg == cols_m2) begin
                        iss_done_next = 1'b1;
                    end else begin
                        cnt_next = COL_CW'(32'(cnt_reg) + 1);
                    end
                end
                if (dv_reg) begin
                    pre_next = pre_new;
                    if ((32'(kd_reg) + 1 >= 32'(wc_reg)) && (win_max < best_reg)) begin
                        best_next  = win_max;
                        pos_next   = COL_AW'(32'(kd_reg) + 1 - 32'(wc_reg));
                        found_next = 1'b1;
                    end
                    if (kd_reg == cols_m2) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                cnt_next = '0;
                if (found_reg && (top_sum <= (HGT_W+2)'(rows_eff))) begin
                    res_next.placed  = 1'b1;
                    res_next.x_texel = POS_W'(32'(pos_reg) << lg_eff);
                    res_next.y_texel = POS_W'(32'(best_reg) << lg_eff);
                    state_next = (wc_reg == '0) ? ST_DONE : ST_WRITE;
                end else begin
                    res_next   = '{placed: 1'b0, x_texel: '0, y_texel: '0};
                    state_next = ST_DONE;
                end
            end
            ST_WRITE: begin
                h_we     = 1'b1;
                h_waddr  = COL_AW'(32'(pos_reg) + 32'(cnt_reg));
                h_wdata  = HGT_W'(top_sum);
                cnt_next = COL_CW'(32'(cnt_reg) + 1);
                if (32'(cnt_reg) + 1 == 32'(wc_reg)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_log2_reg    <= LOG_W'(6);
            block_columns_reg <= CFG_W'(64);
            block_rows_reg    <= CFG_W'(64);
            state_reg         <= ST_INIT;
            cnt_reg           <= '0;
            iss_done_reg      <= 1'b0;
            dv_reg            <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHUNK_LOG2:    chunk_log2_reg    <= cfg_wdata[LOG_W-1:0];
                    REG_BLOCK_COLUMNS: block_columns_reg <= cfg_wdata;
                    REG_BLOCK_ROWS:    block_rows_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            iss_done_reg <= iss_done_next;
            dv_reg       <= dv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kd_reg     <= kd_next;
        seg_reg    <= seg_next;
        suf_reg    <= suf_next;
        pre_reg    <= pre_next;
        best_reg   <= best_next;
        pos_reg    <= pos_next;
        found_reg  <= found_next;
        wc_reg     <= wc_next;
        hc_reg     <= hc_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

endmodule

>>> rtl/sba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks of the skyline block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sba_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input sba_pkg::res_t m_data
);

    import sba_pkg::*;

    a_reset_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken right after reset");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in work");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while the block was free");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");

endmodule

bind skyline_block_allocator sba_checker u_sba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the skyline block allocator. A short table of
// directed requests and register writes covers the extremes of the fields
// and the corner cases of placement. A random part then runs through ten
// register settings under three idling regimes. Every result is compared
// field by field against a table entry or an in-testbench placement predictor.
// ----------------------------------------------------------------------------
module tb;
    import sba_pkg::*;

    localparam int   IDLE_LIMIT  = 20000;
    localparam int   HOLD_CYCLES = 600;
    localparam int   PHASES      = 10;
    localparam int   PHASE_ITEMS = 60;
    localparam res_t RES_FAIL    = '0;
    localparam res_t RES_ORIGIN  = '{1'b1, 14'd0, 14'd0};
    localparam req_t CLEAR_REQ   = '{REQ_CLEAR, 13'd0, 13'd0};

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        req_t                 req;
        bit                   typed;
        res_t                 res;
    } step_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    req_t                 s_data;
    logic                 m_valid;
    logic                 m_ready;
    res_t                 m_data;

    logic [HGT_W-1:0] heights [MAX_COLUMNS];
    int               cur_log2 = 6;
    int               cur_cols = 64;
    int               cur_rows = 64;

    res_t placement_q [$];
    res_t want;
    int   errors = 0;
    int   idle_cycles = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    int   stall_left = 0;
    bit   hold_pending = 1'b0;

    skyline_block_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int eff_log2();
        return (cur_log2 < 4) ? 4 : (cur_log2 > 6) ? 6 : cur_log2;
    endfunction

    function automatic int eff_cols();
        return (cur_cols > MAX_COLUMNS) ? MAX_COLUMNS : cur_cols;
    endfunction

    function automatic int eff_rows();
        return (cur_rows > 256) ? 256 : cur_rows;
    endfunction

    function automatic res_t place_rect(input req_t r);
        int   lg, cols, rows, wc, hc, best, pos, top, j;
        bit   found;
        res_t o;
        lg    = eff_log2();
        cols  = eff_cols();
        rows  = eff_rows();
        o     = '0;
        found = 1'b0;
        pos   = 0;
        if (r.req_type == REQ_CLEAR) begin
            foreach (heights[k]) heights[k] = '0;
            o.placed = 1'b1;
            return o;
        end
        wc   = (int'(r.width_texels) + (1 << lg) - 1) >> lg;
        hc   = (int'(r.height_texels) + (1 << lg) - 1) >> lg;
        best = rows;
        if (wc < cols) begin
            for (int i = 0; i < cols - wc; i++) begin
                top = 0;
                for (j = 0; j < wc; j++) begin
                    if (int'(heights[i + j]) >= best) break;
                    if (int'(heights[i + j]) > top) top = heights[i + j];
                end
                if (j == wc) begin
                    pos   = i;
                    best  = top;
                    found = 1'b1;
                end
            end
        end
        if (!found || best + hc > rows) return o;
        for (int i = 0; i < wc; i++) heights[pos + i] = HGT_W'(best + hc);
        o.placed  = 1'b1;
        o.x_texel = POS_W'(pos << lg);
        o.y_texel = POS_W'(best << lg);
        return o;
    endfunction

    function automatic logic [TEX_W-1:0] texels_for(input int chunks, input int lg);
        int v;
        if (chunks == 0) return '0;
        v = ((chunks - 1) << lg) + $urandom_range(1, 1 << lg);
        if (v > 8191) v = 8191;
        return TEX_W'(v);
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   pick, lg, wmax, hmax;
        pick = $urandom_range(99);
        lg   = eff_log2();
        wmax = (eff_cols() / 4 > 1) ? eff_cols() / 4 : 1;
        hmax = (eff_rows() / 4 > 1) ? eff_rows() / 4 : 1;
        r.width_texels  = TEX_W'($urandom);
        r.height_texels = TEX_W'($urandom);
        if (pick < 6) begin
            r.req_type = REQ_CLEAR;
        end else if (pick < 10) begin
            r.req_type = REQ_ALLOC;
        end else begin
            r.req_type      = REQ_ALLOC;
            r.width_texels  = texels_for($urandom_range(0, wmax), lg);
            r.height_texels = texels_for($urandom_range(1, hmax), lg);
        end
        return r;
    endfunction

    task automatic send_req(input req_t r, input bit typed, input res_t res);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        if (typed) begin
            void'(place_rect(r));
            placement_q.push_back(res);
        end else begin
            placement_q.push_back(place_rect(r));
        end
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (placement_q.size() != 0) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CHUNK_LOG2:    cur_log2 = int'(val[2:0]);
            REG_BLOCK_COLUMNS: cur_cols = int'(val);
            REG_BLOCK_ROWS:    cur_rows = int'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left   = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (placement_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                errors++;
            end else begin
                want = placement_q.pop_front();
                if (m_data.placed !== want.placed) begin
                    $display("%0t: placed mismatch, expected %0d, actual %0d",
                             $time, want.placed, m_data.placed);
                    errors++;
                end
                if (m_data.x_texel !== want.x_texel) begin
                    $display("%0t: x_texel mismatch, expected %0d, actual %0d",
                             $time, want.x_texel, m_data.x_texel);
                    errors++;
                end
                if (m_data.y_texel !== want.y_texel) begin
                    $display("%0t: y_texel mismatch, expected %0d, actual %0d",
                             $time, want.y_texel, m_data.y_texel);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        step_t steps [25];
        int    ph_log2 [PHASES];
        int    ph_cols [PHASES];
        int    ph_rows [PHASES];
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        foreach (heights[k]) heights[k] = '0;
        steps = '{
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd64, 13'd64}, 1'b1, RES_ORIGIN},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, CLEAR_REQ, 1'b1, RES_ORIGIN},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd0, 13'd0}, 1'b1,
              '{1'b1, 14'd4032, 14'd0}},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd8191, 13'd8191}, 1'b1, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd64, 13'd8191}, 1'b1, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd4032, 13'd64}, 1'b1, RES_ORIGIN},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd64, 13'd64}, 1'b1,
              '{1'b1, 14'd0, 14'd64}},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd1, 13'd1}, 1'b0, RES_FAIL},
            '{ROW_CFG, REG_CHUNK_LOG2, 9'd7, '0, 1'b0, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd65, 13'd1}, 1'b0, RES_FAIL},
            '{ROW_CFG, REG_CHUNK_LOG2, 9'd0, '0, 1'b0, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd17, 13'd16}, 1'b0, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, CLEAR_REQ, 1'b1, RES_ORIGIN},
            '{ROW_CFG, REG_BLOCK_COLUMNS, 9'd0, '0, 1'b0, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd16, 13'd16}, 1'b1, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd0, 13'd0}, 1'b1, RES_FAIL},
            '{ROW_CFG, REG_BLOCK_COLUMNS, 9'd511, '0, 1'b0, RES_FAIL},
            '{ROW_CFG, REG_BLOCK_ROWS, 9'd0, '0, 1'b0, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd16, 13'd16}, 1'b1, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd0, 13'd0}, 1'b0, RES_FAIL},
            '{ROW_CFG, REG_BLOCK_ROWS, 9'd511, '0, 1'b0, RES_FAIL},
            '{ROW_CFG, REG_CHUNK_LOG2, 9'd6, '0, 1'b0, RES_FAIL},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd0, 13'd8191}, 1'b1,
              '{1'b1, 14'd16320, 14'd0}},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd4096, 13'd8191}, 1'b1, RES_ORIGIN},
            '{ROW_REQ, REG_CHUNK_LOG2, 9'd0, '{REQ_ALLOC, 13'd4096, 13'd8191}, 1'b0, RES_FAIL}
        };
        ph_log2 = '{4, 5, 6, 7, 0, 5, 6, 0, 0, 0};
        ph_cols = '{16, 256, 1, 300, 40, 0, 256, 0, 0, 0};
        ph_rows = '{16, 256, 1, 511, 8, 100, 256, 0, 0, 0};
        for (int p = 7; p < PHASES; p++) begin
            ph_log2[p] = $urandom_range(0, 7);
            ph_cols[p] = $urandom_range(0, 511);
            ph_rows[p] = $urandom_range(0, 511);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 12;
        rx_idle_pct = 78;
        foreach (steps[k]) begin
            if (steps[k].kind == ROW_CFG) write_reg(steps[k].idx, steps[k].val);
            else send_req(steps[k].req, steps[k].typed, steps[k].res);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p < 4) begin
                tx_idle_pct = 12;
                rx_idle_pct = 78;
            end else if (p < 7) begin
                tx_idle_pct = 78;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(REG_CHUNK_LOG2, CFG_W'(ph_log2[p]));
            write_reg(REG_BLOCK_COLUMNS, CFG_W'(ph_cols[p]));
            write_reg(REG_BLOCK_ROWS, CFG_W'(ph_rows[p]));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 7 && n == 10) hold_pending = 1'b1;
                send_req(random_req(), 1'b0, RES_FAIL);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (placement_q.size() != 0) @(posedge aclk);
        repeat (1000) @(posedge aclk);
        if (errors == 0 && placement_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
